### hw/rtl/julia_escape_time_pixel_top_assert.svh
// Assertion macros used by the checker file of the Julia pixel block.
`ifndef JULIA_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JETP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JETP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/jetp_pkg.sv
package jetp_pkg;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_C_REAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

	localparam logic signed [31:0] C_REAL_RESET = 32'sd95294504;
	localparam logic signed [31:0] C_IMAG_RESET = 32'sd95294504;
	localparam logic [15:0]        LIMIT_RESET  = 16'd1000;

	localparam logic [15:0] BRIGHT_SCALE = 16'd65025;

	localparam int ROOT_W = 16;
	localparam logic [ROOT_W-1:0] ROOT_BIT0 = 16'h4000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_CHECK,
		ST_DIV,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_EMIT
	} jetp_state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic step;
		logic div_start;
		logic div_step;
		logic sqrt_start;
		logic sqrt_step;
		logic emit;
		logic emit_inside;
	} jetp_cmd_t;

	typedef struct packed {
		logic at_limit;
		logic escape;
	} jetp_iter_stat_t;

	typedef struct packed {
		logic div_last;
		logic sqrt_last;
	} jetp_scale_stat_t;

endpackage

### hw/rtl/jetp_ifaces.sv
interface jetp_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] start_real;
	logic signed [31:0] start_imag;

	modport source (output valid, output start_real, output start_imag, input ready);
	modport sink (input valid, input start_real, input start_imag, output ready);
endinterface

interface jetp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  brightness;
	logic [15:0] escape_count;
	logic        inside_res;

	modport source (output valid, output brightness, output escape_count, output inside_res,
		input ready);
	modport sink (input valid, input brightness, input escape_count, input inside_res,
		output ready);
endinterface

interface jetp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [jetp_pkg::CFG_IDX_W-1:0]   index;
	logic [31:0]                      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/julia_escape_time_pixel_top.sv
// Channel   Dir   Word
// cfg       in    index (0 c_real, 1 c_imag, 2 iteration_limit), data
// pix_in    in    start_real, start_imag
// pix_out   out   brightness, escape_count, inside_res
//
// Each step of z*z + c passes through the three product registers and then through the add,
// saturate and escape compare. The brightness of an escaped pixel is a divide followed by a
// square root. Reset returns the constant and the limit to their defaults. A stalled result
// word is held in the output register while the next pixel is accepted and iterated.
module julia_escape_time_pixel_top #(
	parameter int FRAC_BITS  = 28,
	parameter int COUNT_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	jetp_cfg_if.sink     cfg,
	jetp_in_if.sink      pix_in,
	jetp_out_if.source   pix_out
);
	import jetp_pkg::*;

	jetp_cmd_t             cmd;
	jetp_iter_stat_t       istat;
	jetp_scale_stat_t      sstat;
	logic [COUNT_BITS-1:0] count;
	logic [COUNT_BITS-1:0] limit;

	assign cfg.ready = 1'b1;

	jetp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.istat     (istat),
		.sstat     (sstat),
		.cmd       (cmd)
	);

	jetp_iter #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (istat),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.start_real (pix_in.start_real),
		.start_imag (pix_in.start_imag),
		.count      (count),
		.limit      (limit)
	);

	jetp_scale #(
		.COUNT_BITS (COUNT_BITS)
	) u_scale (
		.clk          (clk),
		.cmd          (cmd),
		.stat         (sstat),
		.count        (count),
		.limit        (limit),
		.brightness   (pix_out.brightness),
		.escape_count (pix_out.escape_count),
		.inside_res   (pix_out.inside_res)
	);

endmodule

### hw/rtl/jetp_iter.sv
module jetp_iter #(
	parameter int FRAC_BITS  = 28,
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  jetp_pkg::jetp_cmd_t            cmd,
	output jetp_pkg::jetp_iter_stat_t      stat,
	input  logic                           cfg_we,
	input  logic [jetp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic signed [31:0]             start_real,
	input  logic signed [31:0]             start_imag,
	output logic [COUNT_BITS-1:0]          count,
	output logic [COUNT_BITS-1:0]          limit
);
	import jetp_pkg::*;

	localparam int PROD_W = 64;
	localparam int SQ_W   = PROD_W - FRAC_BITS;
	localparam int XAB_W  = PROD_W - FRAC_BITS + 1;
	localparam int SUM_W  = (SQ_W + 1 > FRAC_BITS + 3) ? SQ_W + 1 : FRAC_BITS + 3;
	localparam int ACC_W  = ((SQ_W > 32) ? SQ_W : 32) + 2;
	localparam int LIM_W  = (COUNT_BITS < 16) ? COUNT_BITS : 16;
	localparam logic [SUM_W-1:0] BOUND = SUM_W'(4) << FRAC_BITS;

	logic signed [31:0]        c_real_q;
	logic signed [31:0]        c_imag_q;
	logic [COUNT_BITS-1:0]     limit_q;
	logic signed [31:0]        a_q;
	logic signed [31:0]        b_q;
	logic [COUNT_BITS-1:0]     n_q;
	logic signed [PROD_W-1:0]  paa_s1;
	logic signed [PROD_W-1:0]  pbb_s1;
	logic signed [PROD_W-1:0]  pab_s1;

	logic [SQ_W-1:0]           aa;
	logic [SQ_W-1:0]           bb;
	logic signed [SQ_W:0]      aa_s;
	logic signed [SQ_W:0]      bb_s;
	logic [SUM_W-1:0]          mag;
	logic signed [XAB_W-1:0]   xab;
	logic signed [ACC_W-1:0]   na;
	logic signed [ACC_W-1:0]   nb;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-32:0] hi;
		hi = v[ACC_W-1:31];
		if ((&hi) || !(|hi)) begin
			return v[31:0];
		end else if (v[ACC_W-1]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7FFF_FFFF;
		end
	endfunction

	assign aa   = paa_s1[PROD_W-1:FRAC_BITS];
	assign bb   = pbb_s1[PROD_W-1:FRAC_BITS];
	assign aa_s = {1'b0, aa};
	assign bb_s = {1'b0, bb};
	assign mag  = SUM_W'(aa) + SUM_W'(bb);
	assign xab  = pab_s1[PROD_W-1:FRAC_BITS-1];
	assign na   = ACC_W'(aa_s) - ACC_W'(bb_s) + ACC_W'(c_real_q);
	assign nb   = ACC_W'(xab) + ACC_W'(c_imag_q);

	assign stat.at_limit = (n_q == limit_q);
	assign stat.escape   = (mag > BOUND);
	assign count         = n_q;
	assign limit         = limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q <= C_REAL_RESET;
			c_imag_q <= C_IMAG_RESET;
			limit_q  <= COUNT_BITS'(LIMIT_RESET[LIM_W-1:0]);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_C_REAL: begin
					c_real_q <= cfg_data;
				end
				CFG_C_IMAG: begin
					c_imag_q <= cfg_data;
				end
				CFG_LIMIT: begin
					limit_q <= COUNT_BITS'(cfg_data[LIM_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= start_real;
			b_q <= start_imag;
			n_q <= '0;
		end else if (cmd.step) begin
			a_q <= sat32(na);
			b_q <= sat32(nb);
			n_q <= n_q + 1'b1;
		end
		if (cmd.mul) begin
			paa_s1 <= PROD_W'(a_q) * PROD_W'(a_q);
			pbb_s1 <= PROD_W'(b_q) * PROD_W'(b_q);
			pab_s1 <= PROD_W'(a_q) * PROD_W'(b_q);
		end
	end

endmodule

### hw/rtl/jetp_scale.sv
module jetp_scale #(
	parameter int COUNT_BITS = 16
) (
	input  logic                        clk,
	input  jetp_pkg::jetp_cmd_t         cmd,
	output jetp_pkg::jetp_scale_stat_t  stat,
	input  logic [COUNT_BITS-1:0]       count,
	input  logic [COUNT_BITS-1:0]       limit,
	output logic [7:0]                  brightness,
	output logic [15:0]                 escape_count,
	output logic                        inside_res
);
	import jetp_pkg::*;

	localparam int DVD_W  = 16 + COUNT_BITS;
	localparam int DCNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0]      dvd_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic [ROOT_W-1:0]     x_q;
	logic [ROOT_W-1:0]     r_q;
	logic [ROOT_W-1:0]     bit_q;
	logic [7:0]            bright_q;
	logic [15:0]           count_q;
	logic                  inside_q;

	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  ge;
	logic [ROOT_W:0]       rb;
	logic                  take;
	logic [31:0]           count_ext;

	assign trial     = {rem_q, dvd_q[DVD_W-1]};
	assign ge        = (trial >= {1'b0, limit});
	assign diff      = trial - {1'b0, limit};
	assign rb        = {1'b0, r_q} + {1'b0, bit_q};
	assign take      = ({1'b0, x_q} >= rb);
	assign count_ext = 32'(count);

	assign stat.div_last  = (dcnt_q == DCNT_W'(DVD_W - 1));
	assign stat.sqrt_last = bit_q[0];

	assign brightness   = bright_q;
	assign escape_count = count_q;
	assign inside_res   = inside_q;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q  <= DVD_W'(BRIGHT_SCALE) * DVD_W'(count);
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			dvd_q  <= {dvd_q[DVD_W-2:0], ge};
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.sqrt_start) begin
			x_q   <= dvd_q[ROOT_W-1:0];
			r_q   <= '0;
			bit_q <= ROOT_BIT0;
		end else if (cmd.sqrt_step) begin
			if (take) begin
				x_q <= x_q - rb[ROOT_W-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.emit) begin
			inside_q <= cmd.emit_inside;
			bright_q <= cmd.emit_inside ? 8'd0 : r_q[7:0];
			count_q  <= count_ext[15:0];
		end
	end

endmodule

### hw/rtl/jetp_ctrl.sv
module jetp_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  jetp_pkg::jetp_iter_stat_t   istat,
	input  jetp_pkg::jetp_scale_stat_t  sstat,
	output jetp_pkg::jetp_cmd_t         cmd
);
	import jetp_pkg::*;

	jetp_state_t state_q;
	jetp_state_t state_d;
	logic        inside_q;
	logic        inside_d;
	logic        out_valid_q;
	logic        out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			inside_q    <= inside_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		inside_d = inside_q;
		cmd      = '0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					inside_d = 1'b0;
					state_d  = ST_TEST;
				end
			end
			ST_TEST: begin
				if (istat.at_limit) begin
					inside_d = 1'b1;
					state_d  = ST_EMIT;
				end else begin
					cmd.mul = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (istat.escape) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_TEST;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sstat.div_last) begin
					state_d = ST_ROOT_INIT;
				end
			end
			ST_ROOT_INIT: begin
				cmd.sqrt_start = 1'b1;
				state_d        = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.sqrt_step = 1'b1;
				if (sstat.sqrt_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit        = 1'b1;
					cmd.emit_inside = inside_q;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cmd.emit) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/jetp_check.sv
`include "julia_escape_time_pixel_top_assert.svh"

module jetp_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  brightness,
	input logic [15:0] escape_count,
	input logic        inside_res
);

	`JETP_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(brightness) && $stable(escape_count) && $stable(inside_res), "stalled result word changed")
	`JETP_ASSERT_IMP(a_inside_dark, clk, arst_n, out_valid && inside_res, brightness == 8'd0, "inside pixel with nonzero brightness")
	`JETP_ASSERT_IMP(a_bright_range, clk, arst_n, out_valid && !inside_res, brightness != 8'd255, "escaped pixel brightness out of range")
	`JETP_ASSERT_NXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready, "second pixel accepted while one is in work")

endmodule

bind julia_escape_time_pixel_top jetp_check u_jetp_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pix_in.valid),
	.in_ready     (pix_in.ready),
	.out_valid    (pix_out.valid),
	.out_ready    (pix_out.ready),
	.brightness   (pix_out.brightness),
	.escape_count (pix_out.escape_count),
	.inside_res   (pix_out.inside_res)
);

### tb/sv/julia_escape_time_pixel_top_tb.sv
`timescale 1ns / 100ps

module julia_escape_time_pixel_top_tb;
	import jetp_pkg::*;

	localparam int FRAC = 28;
	localparam longint ESC_BOUND = 64'sd1073741824;
	localparam longint WIDE_MAX = 64'sd2147483647;
	localparam longint WIDE_MIN = -64'sd2147483648;
	localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S_MIN = 32'sh80000000;
	localparam logic signed [31:0] TWO = 32'sd536870912;
	localparam logic signed [31:0] ROOT_TWO = 32'sd379625062;
	localparam logic signed [31:0] SLOW_C = 32'sd69793218;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int TOTAL_ITEMS = 590;
	localparam int CALM_ITEMS = 100;
	localparam int HOLD_CYCLES = 600;
	localparam int WATCHDOG_LIMIT = 500000;

	typedef struct packed {
		logic [7:0]  brightness;
		logic [15:0] escape_count;
		logic        inside_res;
	} pixel_word_t;

	class pixel_scoreboard;
		logic signed [31:0] c_re;
		logic signed [31:0] c_im;
		logic [15:0]        iter_limit;
		pixel_word_t        pending_q[$];
		int                 mismatches;
		int                 pixels;
		int                 words;
		int                 inside_words;
		int                 reg_writes;

		function new();
			c_re = C_REAL_RESET;
			c_im = C_IMAG_RESET;
			iter_limit = LIMIT_RESET;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			reg_writes++;
			case (idx)
				CFG_C_REAL: c_re = data;
				CFG_C_IMAG: c_im = data;
				CFG_LIMIT: iter_limit = data[15:0];
				default: ;
			endcase
		endfunction

		function longint clamp32(longint v);
			if (v > WIDE_MAX)
				return WIDE_MAX;
			if (v < WIDE_MIN)
				return WIDE_MIN;
			return v;
		endfunction

		function logic [7:0] root_floor(longint x);
			longint r;
			longint t;
			r = 0;
			for (int i = 7; i >= 0; i--) begin
				t = r | (64'sd1 << i);
				if (t * t <= x)
					r = t;
			end
			return r[7:0];
		endfunction

		function pixel_word_t escape_time(logic signed [31:0] sr, logic signed [31:0] si);
			longint      a;
			longint      b;
			longint      aa;
			longint      bb;
			longint      twoab;
			longint      n;
			longint      lim;
			pixel_word_t w;
			a = sr;
			b = si;
			lim = iter_limit;
			n = 0;
			while (n < lim) begin
				aa = (a * a) >>> FRAC;
				bb = (b * b) >>> FRAC;
				if (aa + bb > ESC_BOUND)
					break;
				twoab = (a * b) >>> (FRAC - 1);
				a = clamp32(aa - bb + longint'(c_re));
				b = clamp32(twoab + longint'(c_im));
				n++;
			end
			w.inside_res = (n == lim);
			w.escape_count = n[15:0];
			w.brightness = w.inside_res ? 8'd0 : root_floor((64'sd65025 * n) / lim);
			return w;
		endfunction

		function void note_pixel(logic signed [31:0] sr, logic signed [31:0] si);
			pixels++;
			pending_q.push_back(escape_time(sr, si));
		endfunction

		task report(string msg);
			if (mismatches < 20)
				$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_word(pixel_word_t got);
			pixel_word_t want;
			words++;
			if (pending_q.size() == 0) begin
				report($sformatf("word %0d arrived with no pixel pending", words));
				return;
			end
			want = pending_q.pop_front();
			if (want.inside_res)
				inside_words++;
			if (got.escape_count !== want.escape_count)
				report($sformatf("word %0d escape_count %0d, expected %0d", words,
					got.escape_count, want.escape_count));
			if (got.inside_res !== want.inside_res)
				report($sformatf("word %0d inside_res %0b, expected %0b", words,
					got.inside_res, want.inside_res));
			if (got.brightness !== want.brightness)
				report($sformatf("word %0d brightness %0d, expected %0d", words,
					got.brightness, want.brightness));
		endtask

		task final_check();
			if (pending_q.size() != 0)
				report($sformatf("%0d pixels never produced a word", pending_q.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	bit   hold_now = 1'b0;
	int   sent = 0;
	int   quiet = 0;

	pixel_scoreboard sb = new();

	jetp_cfg_if cfg_bus();
	jetp_in_if  pix_in_bus();
	jetp_out_if pix_out_bus();

	julia_escape_time_pixel_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.pix_in(pix_in_bus),
		.pix_out(pix_out_bus)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && cfg_bus.valid && cfg_bus.ready)
			sb.write_reg(cfg_bus.index, cfg_bus.data);
		if (arst_n && pix_in_bus.valid && pix_in_bus.ready)
			sb.note_pixel(pix_in_bus.start_real, pix_in_bus.start_imag);
		if (arst_n && pix_out_bus.valid && pix_out_bus.ready)
			sb.check_word({pix_out_bus.brightness, pix_out_bus.escape_count,
				pix_out_bus.inside_res});
	end

	always @(posedge clk) begin
		if (!arst_n || (cfg_bus.valid && cfg_bus.ready) || (pix_in_bus.valid && pix_in_bus.ready)
				|| (pix_out_bus.valid && pix_out_bus.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		pix_out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_now) begin
				hold_now = 1'b0;
				pix_out_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				pix_out_bus.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				pix_out_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				pix_out_bus.ready <= 1'b1;
			end else begin
				pix_out_bus.ready <= 1'b1;
			end
		end
	end

	task automatic send_pixel(logic signed [31:0] sr, logic signed [31:0] si);
		pix_in_bus.valid <= 1'b1;
		pix_in_bus.start_real <= sr;
		pix_in_bus.start_imag <= si;
		@(posedge clk);
		while (!pix_in_bus.ready) @(posedge clk);
		sent++;
		if (!calm && $urandom_range(0, 4) == 0) begin
			pix_in_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		pix_in_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(logic signed [31:0] cr, logic signed [31:0] ci, logic [15:0] lim);
		int first;
		first = $urandom_range(0, 2);
		settle();
		for (int k = 0; k < 3; k++) begin
			case ((first + k) % 3)
				0: write_reg(CFG_C_REAL, cr);
				1: write_reg(CFG_C_IMAG, ci);
				default: write_reg(CFG_LIMIT, {16'($urandom_range(0, 65535)), lim});
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_SPARE, $urandom);
	endtask

	function automatic logic signed [31:0] rand_fixed(int unsigned span);
		int unsigned r;
		r = $urandom_range(0, 2 * span);
		return r - span;
	endfunction

	function automatic logic signed [31:0] rand_c();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return rand_fixed(1 << 28);
			6, 7: return rand_fixed(1 << 29);
			8: return $urandom;
			default: return $urandom_range(0, 1) ? S_MAX : S_MIN;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_point();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: return rand_fixed(1 << 29);
			7, 8: return rand_fixed(1 << 30);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_limit();
		case ($urandom_range(0, 11))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'($urandom_range(100, 400));
			default: return 16'($urandom_range(2, 40));
		endcase
	endfunction

	initial begin
		int count;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= CFG_C_REAL;
		cfg_bus.data <= 32'd0;
		pix_in_bus.valid <= 1'b0;
		pix_in_bus.start_real <= 32'sd0;
		pix_in_bus.start_imag <= 32'sd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Constant and limit as they come out of reset.
		send_pixel(32'sd0, 32'sd0);
		send_pixel(S_MIN, S_MIN);
		send_pixel(S_MAX, S_MAX);
		send_pixel(S_MIN, S_MAX);
		send_pixel(S_MAX, S_MIN);
		send_pixel(TWO, 32'sd0);
		send_pixel(32'sd0, 32'sd1);

		// A zero limit reports every pixel as inside without any step.
		configure(32'sd0, 32'sd0, 16'd0);
		send_pixel(32'sd0, 32'sd0);
		send_pixel(S_MAX, S_MIN);

		// Both components of z run past the top and the bottom of the range.
		configure(S_MAX, S_MAX, 16'd3);
		send_pixel(TWO, 32'sd0);
		send_pixel(ROOT_TWO, ROOT_TWO);
		send_pixel(ROOT_TWO, -ROOT_TWO);
		configure(S_MIN, S_MIN, 16'd3);
		send_pixel(32'sd0, TWO);
		send_pixel(ROOT_TWO, -ROOT_TWO);

		// Largest limit: a slow escape just past the cusp, then a fixed point.
		configure(SLOW_C, 32'sd0, 16'hffff);
		send_pixel(32'sd0, 32'sd0);
		send_pixel(S_MAX, 32'sd0);
		configure(32'sd0, 32'sd0, 16'hffff);
		send_pixel(32'sd0, 32'sd0);

		// The output is held off while pixels keep coming, so the input backs up.
		configure(rand_fixed(1 << 28), rand_fixed(1 << 28), 16'd6);
		hold_now = 1'b1;
		repeat (30) send_pixel(rand_point(), rand_point());

		while (sent < TOTAL_ITEMS) begin
			configure(rand_c(), rand_c(), rand_limit());
			calm = (sent >= TOTAL_ITEMS - CALM_ITEMS);
			count = $urandom_range(30, 60);
			if (count > TOTAL_ITEMS - sent)
				count = TOTAL_ITEMS - sent;
			repeat (count) send_pixel(rand_point(), rand_point());
		end

		settle();
		repeat (100) @(posedge clk);
		sb.final_check();
		$display("Ran %0d pixels through %0d register writes: %0d inside, %0d escaped.",
			sb.pixels, sb.reg_writes, sb.inside_words, sb.words - sb.inside_words);
		$display("Field mismatches counted: %0d.", sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
